/* sv/rid_pkg.sv */
package rid_pkg;

	// default cap on the alphabet length
	localparam int MAX_BASE_DEF = 16;

	// widths fixed by the field definitions
	localparam int NUM_W      = 32;
	localparam int CHAR_W     = 8;
	localparam int ALPHA_N    = 16;
	localparam int RADIX_W    = 5;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 32;
	localparam int DIDX_W     = $clog2(MAX_DIGITS);
	localparam int ND_W       = DIDX_W + 1;
	localparam int REG_W      = 64;
	localparam int ADDR_W     = 5;

	// divider: one byte of the dividend per cycle
	localparam int BYTE_W     = 8;
	localparam int DIV_STEPS  = NUM_W / BYTE_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// queue between front and back
	localparam int QDEPTH     = 2;

	// register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
	localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
	localparam logic [1:0] REG_RADIX_LEN  = 2'd2;

	// special characters
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	typedef logic [ALPHA_N-1:0][CHAR_W-1:0] alpha_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		alpha_t             alphabet;
	} cfg_info_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] mag;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_EMIT
	} bk_state_t;

endpackage

/* sv/rid_cfg.sv */
module rid_cfg import rid_pkg::*; #(
	parameter int MAX_BASE = MAX_BASE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	output cfg_info_t         cfg
);

	localparam logic [RADIX_W-1:0] CAP_MAX = RADIX_W'(MAX_BASE);

	logic [REG_W-1:0]   alpha_lo_q;
	logic [REG_W-1:0]   alpha_hi_q;
	logic [RADIX_W-1:0] rlen_q;
	logic               wr_en;
	alpha_t             alpha;
	logic [RADIX_W-1:0] cap;
	logic [RADIX_W-1:0] len;
	logic               stop;
	logic               bad;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_lo_q <= '0;
			alpha_hi_q <= '0;
			rlen_q     <= '0;
		end else if (wr_en) begin
			case (paddr[4:3])
				REG_ALPHA_LOW:  alpha_lo_q <= pwdata;
				REG_ALPHA_HIGH: alpha_hi_q <= pwdata;
				REG_RADIX_LEN:  rlen_q     <= pwdata[RADIX_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[4:3])
			REG_ALPHA_LOW:  prdata = alpha_lo_q;
			REG_ALPHA_HIGH: prdata = alpha_hi_q;
			REG_RADIX_LEN:  prdata = {{(REG_W-RADIX_W){1'b0}}, rlen_q};
			default:        prdata = '0;
		endcase
	end

	assign alpha = alpha_t'({alpha_hi_q, alpha_lo_q});

	// usable length: capped, ends at the first nul byte
	always_comb begin
		cap  = (rlen_q > CAP_MAX) ? CAP_MAX : rlen_q;
		len  = '0;
		stop = 1'b0;
		for (int i = 0; i < ALPHA_N; i++) begin
			if (!stop) begin
				if (RADIX_W'(i) < cap && alpha[i] != CHAR_NUL) begin
					len = RADIX_W'(i + 1);
				end else begin
					stop = 1'b1;
				end
			end
		end
	end

	// sign characters and repeats make the alphabet unusable
	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < ALPHA_N; i++) begin
			if (RADIX_W'(i) < len) begin
				if (alpha[i] == CHAR_MINUS || alpha[i] == CHAR_PLUS) begin
					bad = 1'b1;
				end
				for (int k = i + 1; k < ALPHA_N; k++) begin
					if (RADIX_W'(k) < len && alpha[k] == alpha[i]) begin
						bad = 1'b1;
					end
				end
			end
		end
	end

	assign cfg.radix    = (len < RADIX_W'(2) || bad) ? '0 : len;
	assign cfg.alphabet = alpha;

endmodule

/* sv/rid_front.sv */
module rid_front import rid_pkg::*; (
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [NUM_W-1:0] number,
	input  cfg_info_t        cfg,
	input  logic             q_full,
	output logic             q_push,
	output item_t            q_item
);

	// hold the source only while the queue is full
	assign in_stall = q_full;

	// a beat under an unusable alphabet is taken and dropped
	assign q_push = in_valid & ~q_full & (cfg.radix != '0);

	// sign and magnitude; the most negative value wraps to its true magnitude
	assign q_item.neg = number[NUM_W-1];
	assign q_item.mag = number[NUM_W-1] ? (NUM_W'(0) - number) : number;

endmodule

/* sv/rid_queue.sv */
module rid_queue import rid_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t din,
	input  logic  pop,
	output item_t dout,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CNT_W = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

	item_t            mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

/* sv/rid_back.sv */
module rid_back import rid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_info_t         cfg,
	input  logic              q_empty,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] character,
	output logic              final_char
);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

	bk_state_t           state_q;
	bk_state_t           state_d;
	logic [NUM_W-1:0]    work_q;
	logic [NUM_W-1:0]    work_d;
	logic [DIGIT_W-1:0]  rem_q;
	logic [DIGIT_W-1:0]  rem_next;
	logic [BYTE_W-1:0]   qbyte;
	logic [STEP_W-1:0]   step_q;
	logic [ND_W-1:0]     nd_q;
	logic [DIDX_W-1:0]   idx_q;
	logic                neg_q;
	logic [DIGIT_W-1:0]  digits_q [MAX_DIGITS];
	logic                out_valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                final_q;
	logic                load_ok;
	logic                div_step;
	logic                digit_done;
	logic                load_sign;
	logic                load_digit;

	assign load_ok    = ~out_valid_q | ~out_stall;
	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign final_char = final_q;

	// one byte of restoring division by the radix per cycle
	always_comb begin
		logic [RADIX_W-1:0] r;
		r = (step_q == '0) ? '0 : {1'b0, rem_q};
		for (int j = BYTE_W - 1; j >= 0; j--) begin
			r = {r[RADIX_W-2:0], work_q[NUM_W-BYTE_W+j]};
			if (r >= cfg.radix) begin
				r        = r - cfg.radix;
				qbyte[j] = 1'b1;
			end else begin
				qbyte[j] = 1'b0;
			end
		end
		rem_next = r[DIGIT_W-1:0];
		work_d   = {work_q[NUM_W-BYTE_W-1:0], qbyte};
	end

	// sequencer: fetch, divide, sign, digits
	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		div_step   = 1'b0;
		digit_done = 1'b0;
		load_sign  = 1'b0;
		load_digit = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				div_step = 1'b1;
				if (step_q == STEP_LAST) begin
					digit_done = 1'b1;
					if (work_d == '0) begin
						state_d = neg_q ? BK_SIGN : BK_EMIT;
					end
				end
			end
			BK_SIGN: begin
				if (load_ok) begin
					load_sign = 1'b1;
					state_d   = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (load_ok) begin
					load_digit = 1'b1;
					if (idx_q == '0) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			nd_q        <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				step_q <= '0;
				nd_q   <= '0;
			end else if (div_step) begin
				step_q <= (step_q == STEP_LAST) ? '0 : step_q + 1'b1;
				if (digit_done) begin
					nd_q  <= nd_q + 1'b1;
					idx_q <= nd_q[DIDX_W-1:0];
				end
			end else if (load_digit && idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
			if (load_sign || load_digit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath and output beat
	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_item.mag;
			neg_q  <= q_item.neg;
		end else if (div_step) begin
			work_q <= work_d;
			rem_q  <= rem_next;
		end
		if (digit_done) begin
			digits_q[nd_q[DIDX_W-1:0]] <= rem_next;
		end
		if (load_sign) begin
			char_q  <= CHAR_MINUS;
			final_q <= 1'b0;
		end else if (load_digit) begin
			char_q  <= cfg.alphabet[digits_q[idx_q]];
			final_q <= (idx_q == '0);
		end
	end

endmodule

/* sv/radix_integer_to_digits_top.sv */
// the divider retires one byte of the magnitude per cycle; a digit needs all four bytes
// a two-entry queue lets the next number be taken while the current one is printed
// reset: asynchronous, zeroes the control registers, empties the queue, idles the back end
module radix_integer_to_digits_top import rid_pkg::*; #(
	parameter int MAX_BASE = MAX_BASE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]  pwdata,
	output logic [REG_W-1:0]  prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [NUM_W-1:0]  number,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] character,
	output logic              final_char
);

	cfg_info_t cfg;
	item_t     push_item;
	item_t     pop_item;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	rid_cfg #(
		.MAX_BASE(MAX_BASE)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	rid_front u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.number  (number),
		.cfg     (cfg),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	rid_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (push_item),
		.pop   (q_pop),
		.dout  (pop_item),
		.full  (q_full),
		.empty (q_empty)
	);

	rid_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.final_char(final_char)
	);

endmodule

/* sv/rid_checker.sv */
module rid_checker import rid_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAR_W-1:0] character,
	input logic              final_char
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(final_char))
		else $error("output beat changed while stalled");

	// a minus sign is never the last character
	a_minus_not_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == CHAR_MINUS |-> !final_char)
		else $error("minus sign flagged as last character");

	// a digit follows a taken minus sign at once
	a_minus_then_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && character == CHAR_MINUS |=> out_valid)
		else $error("no digit after minus sign");

endmodule

bind radix_integer_to_digits_top rid_checker u_chk (.*);
